// ----- src/shaxh_pkg.sv -----
`timescale 1ns / 1ps

package shaxh_pkg;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned MASKED_W = 31;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SHL_AMT  = 5;
    localparam int unsigned SHR_AMT  = 2;
    localparam int unsigned CNT_W    = 5;

    localparam logic [0:0] CFG_SEED       = 1'b0;
    localparam logic [0:0] CFG_TABLE_SIZE = 1'b1;

    // One finished word handed from the front to the back.
    typedef struct packed {
        logic                valid;
        logic [MASKED_W-1:0] masked;
    } word_xfer_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // One byte step of the shift-add-xor mix, wrapping at 32 bits.
    function automatic logic [HASH_W-1:0] mix_byte(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] sum;
        sum = (h << SHL_AMT) + {{(HASH_W-BYTE_W){1'b0}}, b} + (h >> SHR_AMT);
        return h ^ sum;
    endfunction

endpackage

// ----- src/shaxh_front.sv -----
`timescale 1ns / 1ps

module shaxh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [shaxh_pkg::HASH_W-1:0]  seed,
    input  logic                          byte_valid,
    input  logic [shaxh_pkg::BYTE_W-1:0]  byte_data,
    input  logic                          byte_last,
    input  logic                          queue_ready,
    output logic                          byte_ready,
    output shaxh_pkg::word_xfer_t         push
);
    import shaxh_pkg::*;

    logic              in_word_reg;
    logic              in_word_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mixed;
    logic              take;

    // A byte is only taken when the queue can hold a word that might end here.
    assign byte_ready = queue_ready;
    assign take       = byte_valid && queue_ready;
    assign mixed      = mix_byte(in_word_reg ? hash_reg : seed, byte_data);

    assign push.valid  = take && byte_last;
    assign push.masked = mixed[MASKED_W-1:0];

    always_comb
    begin
        in_word_next = in_word_reg;
        hash_next    = hash_reg;
        if (take)
        begin
            in_word_next = !byte_last;
            hash_next    = mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
        end
        else
        begin
            in_word_reg <= in_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
    end

endmodule

// ----- src/shaxh_queue.sv -----
`timescale 1ns / 1ps

module shaxh_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  shaxh_pkg::word_xfer_t push,
    output logic                  push_ready,
    input  logic                  pop,
    output shaxh_pkg::word_xfer_t head
);
    import shaxh_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_Q-1:0] FULL_CNT = CNT_Q'(DEPTH);

    logic [MASKED_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_Q-1:0]    count_reg;
    logic [CNT_Q-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready  = (count_reg != FULL_CNT);
    assign head.valid  = (count_reg != '0);
    assign head.masked = mem[rd_ptr_reg];
    assign do_push     = push.valid && push_ready;
    assign do_pop      = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.masked;
        end
    end

endmodule

// ----- src/shaxh_back.sv -----
`timescale 1ns / 1ps

module shaxh_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [shaxh_pkg::HASH_W-1:0]  table_size,
    input  shaxh_pkg::word_xfer_t         head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [shaxh_pkg::HASH_W-1:0]  out_bucket
);
    import shaxh_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [HASH_W-1:0]   rem_reg;
    logic [HASH_W-1:0]   rem_next;
    logic [MASKED_W-1:0] dvd_reg;
    logic [MASKED_W-1:0] dvd_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [HASH_W-1:0]   bucket_reg;
    logic [HASH_W-1:0]   bucket_next;
    logic [HASH_W:0]     shifted;
    logic [HASH_W:0]     diff;
    logic                load_out;

    // Restoring division, one quotient bit per cycle. A zero divisor always
    // subtracts nothing, so the remainder ends as the dividend itself.
    assign shifted = {rem_reg, dvd_reg[MASKED_W-1]};
    assign diff    = shifted - {1'b0, table_size};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            BK_IDLE:
            begin
                pop      = head.valid;
                rem_next = '0;
                dvd_next = head.masked;
                cnt_next = CNT_W'(MASKED_W - 1);
            end
            BK_DIV:
            begin
                rem_next = diff[HASH_W] ? shifted[HASH_W-1:0] : diff[HASH_W-1:0];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
            BK_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        bucket_next    = bucket_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            bucket_next    = rem_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bucket = bucket_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        cnt_reg    <= cnt_next;
        bucket_reg <= bucket_next;
    end

endmodule

// ----- src/shift_add_xor_string_hash.sv -----
`timescale 1ns / 1ps

// Shift-add-xor string hash with bucket reduction.
// Bytes of a word arrive on the slave stream, one byte per transfer, with
// tlast on the final byte. The front hashes one byte per cycle, starting each
// word from the seed register; on the final byte it hands the hash, with bit
// 31 cleared, to a small queue. The back reduces each queued hash modulo
// table_size (a zero table_size leaves the hash unchanged) and presents the
// bucket index on the master stream, one transfer per word.
// Bytes are taken every cycle while the queue has room. The back works on one
// word at a time: a load step, the bit-serial restoring division over the 31
// dividend bits, and a step that moves the remainder into the output register.
// Words that come faster stall the slave side once QUEUE_DEPTH words wait.
// The output register holds its bucket while the receiver stalls; the back
// keeps its finished result and the queue keeps filling meanwhile.
// Configuration is written through cfg_we/cfg_index/cfg_data (index 0 seed,
// index 1 table_size); the user must write it only while the block is idle,
// which the block does not enforce. Reset clears the queue, the output valid
// flag and the word-in-progress flag, and sets seed 0, size 1.
module shift_add_xor_string_hash #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] bucket
);
    import shaxh_pkg::*;

    logic [HASH_W-1:0] seed_reg;
    logic [HASH_W-1:0] seed_next;
    logic [HASH_W-1:0] table_size_reg;
    logic [HASH_W-1:0] table_size_next;
    word_xfer_t        push;
    word_xfer_t        head;
    logic              queue_ready;
    logic              pop;

    always_comb
    begin
        seed_next       = seed_reg;
        table_size_next = table_size_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED:       seed_next       = cfg_data;
                CFG_TABLE_SIZE: table_size_next = cfg_data;
                default:        seed_next       = seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= '0;
            table_size_reg <= HASH_W'(1);
        end
        else
        begin
            seed_reg       <= seed_next;
            table_size_reg <= table_size_next;
        end
    end

    shaxh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .byte_valid  (s_tvalid),
        .byte_data   (s_tdata),
        .byte_last   (s_tlast),
        .queue_ready (queue_ready),
        .byte_ready  (s_tready),
        .push        (push)
    );

    shaxh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (queue_ready),
        .pop        (pop),
        .head       (head)
    );

    shaxh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .table_size (table_size_reg),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_bucket (m_tdata)
    );

endmodule
